// File: rtl/keyed_table_oldest_eviction_macros.svh
// ============================================================================
// Assertion macros for the keyed table
// Concurrent assertion forms used by the top-level RTL file of the block.
// ============================================================================
`ifndef KEYED_TABLE_OLDEST_EVICTION_MACROS_SVH
`define KEYED_TABLE_OLDEST_EVICTION_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KTEO_CHECK(LABEL, CLK, RST, ANTE, CONS) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |-> (CONS)) \
    else $error("keyed table check failed");

// Next-cycle implication, disabled while reset is high.
`define KTEO_CHECK_NEXT(LABEL, CLK, RST, ANTE, CONS) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |=> (CONS)) \
    else $error("keyed table check failed");

`endif

// File: rtl/kteo_pkg.sv
// ============================================================================
// kteo_pkg
// Types and codes shared by the keyed table with oldest-entry eviction.
// ============================================================================
package kteo_pkg;

  localparam int KEY_W  = 48;
  localparam int TIME_W = 32;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;

  // Operation codes carried by the request.
  typedef enum logic [1:0] {
    FUNC_GET    = 2'd0,
    FUNC_PUT    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_NOROOM   = 2'd2;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic              valid;
    logic              pin;
    logic [TIME_W-1:0] last;
    logic [TIME_W-1:0] first;
    logic [KEY_W-1:0]  key;
  } entry_t;

  // Findings of one scan over the table.
  typedef struct packed {
    logic match_found;
    logic free_found;
    logic vict_found;
  } scan_flags_t;

endpackage

// File: rtl/kteo_ram.sv
// ============================================================================
// kteo_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module kteo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/kteo_scan.sv
// ============================================================================
// kteo_scan
// Per-slot evaluation unit: key match, first free slot and oldest victim.
// ============================================================================
module kteo_scan #(
  parameter int AW = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       eval,
  input  logic [AW-1:0]              slot,
  input  kteo_pkg::entry_t           word,
  input  logic [kteo_pkg::KEY_W-1:0] key,
  output kteo_pkg::scan_flags_t      flags,
  output logic [AW-1:0]              match_slot,
  output kteo_pkg::entry_t           match_word,
  output logic [AW-1:0]              free_slot,
  output logic [AW-1:0]              vict_slot,
  output logic [kteo_pkg::KEY_W-1:0] vict_key
);
  import kteo_pkg::*;

  logic [TIME_W-1:0] vict_age;
  logic [TIME_W-1:0] age;
  logic              hit;
  logic              older;

  // Age is the last-seen time, or the first-seen time when never seen since.
  assign age   = (word.last != '0) ? word.last : word.first;
  assign hit   = word.valid && (word.key == key);
  assign older = !flags.vict_found || (age < vict_age);

  // Track the first match, the first free slot and the oldest unpinned entry.
  always_ff @(posedge clk) begin
    if (rst || start) begin
      flags <= '0;
    end else if (eval) begin
      if (hit && !flags.match_found) begin
        flags.match_found <= 1'b1;
        match_slot        <= slot;
        match_word        <= word;
      end
      if (!word.valid && !flags.free_found) begin
        flags.free_found <= 1'b1;
        free_slot        <= slot;
      end
      if (word.valid && !word.pin && older) begin
        flags.vict_found <= 1'b1;
        vict_slot        <= slot;
        vict_key         <= word.key;
        vict_age         <= age;
      end
    end
  end

endmodule

// File: rtl/keyed_table_oldest_eviction.sv
// ============================================================================
// keyed_table_oldest_eviction
// Table keyed by a 48-bit address with get, put, remove and read-slot, and
// oldest-age eviction of unpinned entries when a put finds the table full.
// ============================================================================
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   request  | in_valid / in_ready  | func key_in first_time_in last_time_in
//            |                      | pinned_in slot_index
//   result   | out_valid / out_ready| status slot_out key_out first_time_out
//            |                      | last_time_out pinned_out evicted
//            |                      | evicted_key used_total extent_total
//
// Get, put and remove scan the slots below the extent, one slot read per
// cycle, through the single read port of the entry memory feeding one shared
// compare unit, and skip the scan when the table has never been used; read
// slot takes a single read. The next request is taken in the cycle after a
// result is issued. Reset clears counts and control, not the entries:
// slots at or above the high-water mark are never used, so no clearing pass
// is needed. A stalled result holds in the output register; a new request is
// taken meanwhile, and its result waits until the previous one has been taken.
//
`include "keyed_table_oldest_eviction_macros.svh"

module keyed_table_oldest_eviction #(
  parameter int ENTRY_COUNT = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  func,
  input  logic [kteo_pkg::KEY_W-1:0]  key_in,
  input  logic [kteo_pkg::TIME_W-1:0] first_time_in,
  input  logic [kteo_pkg::TIME_W-1:0] last_time_in,
  input  logic                        pinned_in,
  input  logic [kteo_pkg::IDX_W-1:0]  slot_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [kteo_pkg::IDX_W-1:0]  slot_out,
  output logic [kteo_pkg::KEY_W-1:0]  key_out,
  output logic [kteo_pkg::TIME_W-1:0] first_time_out,
  output logic [kteo_pkg::TIME_W-1:0] last_time_out,
  output logic                        pinned_out,
  output logic                        evicted,
  output logic [kteo_pkg::KEY_W-1:0]  evicted_key,
  output logic [kteo_pkg::CNT_W-1:0]  used_total,
  output logic [kteo_pkg::CNT_W-1:0]  extent_total
);
  import kteo_pkg::*;

  localparam int AW = $clog2(ENTRY_COUNT);
  localparam int CW = $clog2(ENTRY_COUNT + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_READ,
    S_DECIDE
  } state_t;

  state_t             state;
  func_t              op;
  logic [KEY_W-1:0]   req_key;
  logic [TIME_W-1:0]  req_first;
  logic [TIME_W-1:0]  req_last;
  logic               req_pin;
  logic [IDX_W-1:0]   req_idx;
  logic [AW-1:0]      ptr;
  logic               dv;
  logic [AW-1:0]      di;
  logic [CW-1:0]      extent;
  logic [CW-1:0]      live;

  logic               accept;
  logic               fire;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  entry_t             rd_word;

  scan_flags_t        flags;
  logic [AW-1:0]      match_slot;
  entry_t             match_word;
  logic [AW-1:0]      free_slot;
  logic [AW-1:0]      vict_slot;
  logic [KEY_W-1:0]   vict_key;

  logic [XW-1:0]      idx_x;
  logic [XW-1:0]      ext_x;
  logic [CW-1:0]      put_end;
  logic [CW-1:0]      extent_next;
  logic [CW-1:0]      live_next;
  logic [1:0]         res_status;
  logic [IDX_W-1:0]   res_slot;
  entry_t             res_word;
  logic               res_evicted;
  logic [KEY_W-1:0]   res_evicted_key;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fire     = (state == S_DECIDE) && (!out_valid || out_ready);

  assign idx_x   = XW'(req_idx);
  assign ext_x   = XW'(extent);

  // Read port: one slot per cycle while scanning, one read for read slot.
  assign ram_re    = (state == S_SCAN) || (state == S_READ);
  assign ram_raddr = (state == S_READ) ? AW'(idx_x) : ptr;

  kteo_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRY_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_word)
  );

  kteo_scan #(
    .AW (AW)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .eval       (dv),
    .slot       (di),
    .word       (rd_word),
    .key        (req_key),
    .flags      (flags),
    .match_slot (match_slot),
    .match_word (match_word),
    .free_slot  (free_slot),
    .vict_slot  (vict_slot),
    .vict_key   (vict_key)
  );

  // Decision once the scan is done: result, memory write and new counts.
  always_comb begin
    res_status      = ST_OK;
    res_slot        = '0;
    res_word        = '0;
    res_evicted     = 1'b0;
    res_evicted_key = '0;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    put_end         = '0;
    extent_next     = extent;
    live_next       = live;
    unique case (op)
      FUNC_GET: begin
        if (flags.match_found) begin
          res_slot = IDX_W'(match_slot);
          res_word = match_word;
        end else begin
          res_status = ST_NOTFOUND;
        end
      end
      FUNC_PUT: begin
        ram_wdata.valid = 1'b1;
        ram_wdata.pin   = req_pin;
        ram_wdata.last  = req_last;
        ram_wdata.first = req_first;
        ram_wdata.key   = req_key;
        if (flags.match_found) begin
          ram_waddr = match_slot;
          ram_we    = fire;
        end else if (flags.free_found) begin
          ram_waddr = free_slot;
          ram_we    = fire;
          live_next = live + CW'(1);
        end else if (extent < CW'(ENTRY_COUNT)) begin
          ram_waddr = AW'(extent);
          ram_we    = fire;
          live_next = live + CW'(1);
        end else if (flags.vict_found) begin
          ram_waddr       = vict_slot;
          ram_we          = fire;
          res_evicted     = 1'b1;
          res_evicted_key = vict_key;
        end else begin
          res_status = ST_NOROOM;
        end
        if (res_status == ST_OK) begin
          res_slot = IDX_W'(ram_waddr);
          res_word = ram_wdata;
          put_end  = CW'(ram_waddr) + CW'(1);
          if (put_end > extent) begin
            extent_next = put_end;
          end
        end
      end
      FUNC_REMOVE: begin
        if (flags.match_found) begin
          ram_waddr = match_slot;
          ram_we    = fire;
          res_slot  = IDX_W'(match_slot);
          live_next = live - CW'(1);
        end
      end
      FUNC_READ: begin
        if ((idx_x < ext_x) && rd_word.valid) begin
          res_slot = req_idx;
          res_word = rd_word;
        end else begin
          res_status = ST_NOTFOUND;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
    // The valid bit travels only with an entry that is stored, never with a reported one.
    res_word.valid = 1'b0;
  end

  // Sequencer, request registers, counts and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dv        <= 1'b0;
      extent    <= '0;
      live      <= '0;
      out_valid <= 1'b0;
    end else begin
      dv <= (state == S_SCAN);
      di <= ptr;
      if (out_valid && out_ready && !fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op        <= func_t'(func);
            req_key   <= key_in;
            req_first <= first_time_in;
            req_last  <= last_time_in;
            req_pin   <= pinned_in;
            req_idx   <= slot_index;
            ptr       <= '0;
            if (func_t'(func) == FUNC_READ) begin
              state <= S_READ;
            end else if (extent == '0) begin
              state <= S_DECIDE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (ptr == AW'(extent - CW'(1))) begin
            state <= S_TAIL;
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        S_TAIL: begin
          state <= S_DECIDE;
        end
        S_READ: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (fire) begin
            state          <= S_IDLE;
            extent         <= extent_next;
            live           <= live_next;
            out_valid      <= 1'b1;
            status         <= res_status;
            slot_out       <= res_slot;
            key_out        <= res_word.key;
            first_time_out <= res_word.first;
            last_time_out  <= res_word.last;
            pinned_out     <= res_word.pin;
            evicted        <= res_evicted;
            evicted_key    <= res_evicted_key;
            used_total     <= CNT_W'(live_next);
            extent_total   <= CNT_W'(extent_next);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Consistency of the counts and of the sequencer.
  `KTEO_CHECK(a_live_within_extent, clk, rst, 1'b1, live <= extent)
  `KTEO_CHECK(a_extent_within_depth, clk, rst, 1'b1, extent <= CW'(ENTRY_COUNT))
  `KTEO_CHECK_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `KTEO_CHECK(a_scan_needs_entries, clk, rst, state == S_SCAN, extent != '0)

endmodule
